>>> hdl/cfs_pkg.sv
// Shared types and constants for the channel frequency stepper.
package cfs_pkg;

  localparam int FreqW = 27;
  localparam int CountW = 8;
  localparam int StepW = 16;
  localparam int SumW = FreqW + 2;
  localparam int ProdW = CountW + StepW + 1;
  localparam int OffW = FreqW + 1;
  localparam int QuotW = 17;
  localparam int RemW = 12;
  localparam int IndexW = 2;

  localparam int unsigned Grid833 = 833;
  localparam int unsigned GridBlock = 2500;
  localparam int RecipShift = 40;
  localparam logic [28:0] RecipMul = 29'd439804652;

  localparam logic [RemW-1:0] Grid833K1 = RemW'(Grid833);
  localparam logic [RemW-1:0] Grid833K2 = RemW'(2 * Grid833 + 1);
  localparam logic [RemW-1:0] Grid833K3 = RemW'(GridBlock - 1);
  localparam logic [RemW-1:0] Bound1 = RemW'(Grid833);
  localparam logic [RemW-1:0] Bound2 = RemW'(2 * Grid833);
  localparam logic [RemW-1:0] Bound3 = RemW'(3 * Grid833);

  localparam logic [FreqW-1:0] LowerReset = FreqW'(13600000);
  localparam logic [FreqW-1:0] UpperReset = FreqW'(17400000);
  localparam logic [StepW-1:0] StepReset = StepW'(1250);

  typedef enum logic [IndexW-1:0] {
    REG_LOWER = 2'd0,
    REG_UPPER = 2'd1,
    REG_STEP  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    WRAP_NONE  = 2'd0,
    WRAP_LOWER = 2'd1,
    WRAP_TOP   = 2'd2
  } wrap_t;

  typedef struct packed {
    logic [FreqW-1:0] lower;
    logic [FreqW-1:0] upper;
    logic [StepW-1:0] step;
  } cfg_t;

endpackage

>>> hdl/cfs_top_grid.sv
// Serial remainder divider that finds the highest grid point of the band.
module cfs_top_grid (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  cfs_pkg::cfg_t                cfg,
  output logic                         busy,
  output logic [cfs_pkg::FreqW-1:0]    top_point
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_FIN   = 4'b0100,
    ST_READY = 4'b1000
  } state_t;

  localparam int CntW = $clog2(cfs_pkg::FreqW + 1);

  state_t                        state;
  logic [CntW-1:0]               cnt;
  logic [cfs_pkg::FreqW-1:0]     num;
  logic [cfs_pkg::StepW-1:0]     den;
  logic [cfs_pkg::StepW-1:0]     rem;
  logic                          inverted;
  logic [cfs_pkg::StepW:0]       trial;
  logic [cfs_pkg::StepW:0]       trial_sub;

  assign trial = {rem, num[cfs_pkg::FreqW-1]};
  assign trial_sub = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt <= '0;
    end else if (cfg_write) begin
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_LOAD: begin
          state <= ST_RUN;
          cnt <= CntW'(cfs_pkg::FreqW);
        end
        ST_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: state <= ST_READY;
        ST_READY: state <= ST_READY;
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        inverted <= cfg.upper < cfg.lower;
        num <= (cfg.upper < cfg.lower) ? '0 : cfg.upper - cfg.lower;
        den <= (cfg.step == '0) ? cfs_pkg::StepW'(1) : cfg.step;
        rem <= '0;
      end
      ST_RUN: begin
        num <= {num[cfs_pkg::FreqW-2:0], 1'b0};
        rem <= trial_sub[cfs_pkg::StepW] ? trial[cfs_pkg::StepW-1:0]
                                         : trial_sub[cfs_pkg::StepW-1:0];
      end
      ST_FIN: begin
        // band top minus (span mod step) is the last grid point
        top_point <= inverted ? cfg.lower
                              : cfg.upper - cfs_pkg::FreqW'(rem);
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_READY);

endmodule

>>> hdl/cfs_step_pipe.sv
// Seven-stage step, snap and wrap datapath with per-stage valid bits.
module cfs_step_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  cfs_pkg::cfg_t                 cfg,
  input  logic [cfs_pkg::FreqW-1:0]     top_point,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cfs_pkg::FreqW-1:0]     in_freq,
  input  logic [cfs_pkg::CountW-1:0]    in_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cfs_pkg::FreqW-1:0]     out_freq,
  output cfs_pkg::wrap_t                out_flag
);

  localparam int NStage = 7;

  logic [NStage-1:0] vld;
  logic [NStage:0]   en;

  assign en[NStage] = out_ready;
  for (genvar i = 0; i < NStage; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NStage; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = vld[NStage-1];

  logic signed [cfs_pkg::SumW-1:0] lo_s;
  logic signed [cfs_pkg::SumW-1:0] hi_s;
  assign lo_s = $signed({2'b00, cfg.lower});
  assign hi_s = $signed({2'b00, cfg.upper});

  // stage 1: step product
  logic [cfs_pkg::FreqW-1:0]        s1_cur;
  logic signed [cfs_pkg::ProdW-1:0] s1_prod;
  logic signed [cfs_pkg::ProdW-1:0] prod;
  assign prod = $signed(in_count) * $signed({1'b0, cfg.step});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_cur <= in_freq;
      s1_prod <= prod;
    end
  end

  // stage 2: signed sum
  logic signed [cfs_pkg::SumW-1:0] s2_f;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_f <= $signed({2'b00, s1_cur})
            + $signed({{(cfs_pkg::SumW - cfs_pkg::ProdW){s1_prod[cfs_pkg::ProdW-1]}},
                       s1_prod});
    end
  end

  // stage 3: offset from band bottom
  logic signed [cfs_pkg::SumW-1:0] s3_f;
  logic [cfs_pkg::OffW-1:0]        s3_d;
  logic                            s3_ge;
  logic signed [cfs_pkg::SumW-1:0] diff;
  assign diff = s2_f - lo_s;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_f <= s2_f;
      s3_d <= diff[cfs_pkg::OffW-1:0];
      s3_ge <= s2_f >= lo_s;
    end
  end

  // stage 4: block index by reciprocal multiply
  localparam int QProdW = cfs_pkg::OffW + 29;
  logic signed [cfs_pkg::SumW-1:0] s4_f;
  logic [cfs_pkg::OffW-1:0]        s4_d;
  logic                            s4_ge;
  logic [cfs_pkg::QuotW-1:0]       s4_q;
  logic [QProdW-1:0]               qprod;
  assign qprod = QProdW'(s3_d) * QProdW'(cfs_pkg::RecipMul);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_f <= s3_f;
      s4_d <= s3_d;
      s4_ge <= s3_ge;
      s4_q <= qprod[cfs_pkg::RecipShift +: cfs_pkg::QuotW];
    end
  end

  // stage 5: block base and remainder
  logic signed [cfs_pkg::SumW-1:0] s5_f;
  logic                            s5_ge;
  logic [cfs_pkg::OffW-1:0]        s5_qb;
  logic [cfs_pkg::RemW-1:0]        s5_r;
  logic [cfs_pkg::SumW-1:0]        qb;
  logic [cfs_pkg::OffW-1:0]        rem_full;
  assign qb = cfs_pkg::SumW'(s4_q) * cfs_pkg::SumW'(cfs_pkg::GridBlock);
  assign rem_full = s4_d - qb[cfs_pkg::OffW-1:0];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_f <= s4_f;
      s5_ge <= s4_ge;
      s5_qb <= qb[cfs_pkg::OffW-1:0];
      s5_r <= rem_full[cfs_pkg::RemW-1:0];
    end
  end

  // stage 6: snap to the 8.33 kHz channel inside the block
  logic signed [cfs_pkg::SumW-1:0] s6_f;
  logic [cfs_pkg::RemW-1:0]        adj;
  logic [cfs_pkg::SumW-1:0]        snapped;
  logic                            snap_en;

  always_comb begin
    priority if (s5_r < cfs_pkg::Bound1) begin
      adj = '0;
    end else if (s5_r < cfs_pkg::Bound2) begin
      adj = cfs_pkg::Grid833K1;
    end else if (s5_r < cfs_pkg::Bound3) begin
      adj = cfs_pkg::Grid833K2;
    end else begin
      adj = cfs_pkg::Grid833K3;
    end
  end

  assign snapped = cfs_pkg::SumW'(cfg.lower) + cfs_pkg::SumW'(s5_qb)
                 + cfs_pkg::SumW'(adj);
  assign snap_en = s5_ge && (cfg.step == cfs_pkg::StepW'(cfs_pkg::Grid833));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_f <= snap_en ? $signed(snapped) : s5_f;
    end
  end

  // stage 7: band wrap into the output register
  always_ff @(posedge clk) begin
    if (en[6]) begin
      priority if (s6_f > hi_s) begin
        out_freq <= cfg.lower;
        out_flag <= cfs_pkg::WRAP_LOWER;
      end else if (s6_f < lo_s) begin
        out_freq <= top_point;
        out_flag <= cfs_pkg::WRAP_TOP;
      end else begin
        out_freq <= s6_f[cfs_pkg::FreqW-1:0];
        out_flag <= cfs_pkg::WRAP_NONE;
      end
    end
  end

endmodule

>>> hdl/channel_frequency_stepper_unit.sv
// Channel frequency stepper: moves a frequency by signed channel steps within the band.
//
// Takes one transfer per clock unless the output stalls or the grid divider is busy,
// and delivers each result through a seven-stage pipeline whose stages stall
// independently, so bubbles close up while the output waits. The highest grid
// point of the band comes from a one-bit-per-cycle remainder divider; it runs
// after reset and after every register write, and s_tready stays low while it runs.
module channel_frequency_stepper_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cfs_pkg::IndexW-1:0]    cfg_index,
  input  logic [cfs_pkg::FreqW-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,  // current_freq[26:0], step_count[34:27]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata   // new_freq[26:0], wrap_flag[28:27]
);

  cfs_pkg::cfg_t                 cfg;
  logic                          busy;
  logic [cfs_pkg::FreqW-1:0]     top_point;
  logic                          pipe_ready;
  logic [cfs_pkg::FreqW-1:0]     out_freq;
  cfs_pkg::wrap_t                out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower <= cfs_pkg::LowerReset;
      cfg.upper <= cfs_pkg::UpperReset;
      cfg.step <= cfs_pkg::StepReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfs_pkg::REG_LOWER: cfg.lower <= cfg_data;
        cfs_pkg::REG_UPPER: cfg.upper <= cfg_data;
        cfs_pkg::REG_STEP:  cfg.step <= cfg_data[cfs_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  cfs_top_grid u_top_grid (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_we),
    .cfg       (cfg),
    .busy      (busy),
    .top_point (top_point)
  );

  cfs_step_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .top_point (top_point),
    .in_valid  (s_tvalid && !busy),
    .in_ready  (pipe_ready),
    .in_freq   (s_tdata[cfs_pkg::FreqW-1:0]),
    .in_count  (s_tdata[cfs_pkg::FreqW +: cfs_pkg::CountW]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_freq  (out_freq),
    .out_flag  (out_flag)
  );

  assign s_tready = pipe_ready && !busy;
  assign m_tdata = {3'b000, out_flag, out_freq};

endmodule

>>> tb/channel_frequency_stepper_unit_tb.sv
// Self-checking testbench for the channel frequency stepper: directed table, then random bands.
module channel_frequency_stepper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [cfs_pkg::FreqW-1:0] FreqMax = '1;
  localparam cfs_pkg::cfg_t ResetBand = '{cfs_pkg::LowerReset, cfs_pkg::UpperReset,
                                          cfs_pkg::StepReset};
  localparam cfs_pkg::cfg_t AirBand   = '{27'd11800000, 27'd13697500, 16'd833};
  localparam cfs_pkg::cfg_t ZeroStep  = '{27'd10000000, 27'd20000000, 16'd0};
  localparam cfs_pkg::cfg_t Crossed   = '{27'd20000000, 27'd10000000, 16'd1250};
  localparam cfs_pkg::cfg_t FullBand  = '{27'd0, FreqMax, 16'hFFFF};
  localparam int PhaseCount = 10;
  localparam int PhaseItems = 190;

  typedef struct {
    logic [cfs_pkg::FreqW-1:0] freq;
    cfs_pkg::wrap_t            wrap;
  } tune_t;

  typedef struct {
    cfs_pkg::cfg_t              band;
    logic [cfs_pkg::FreqW-1:0]  freq;
    logic [cfs_pkg::CountW-1:0] count;
    bit                         typed;
    tune_t                      want;
  } tune_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [cfs_pkg::IndexW-1:0]   cfg_index = '0;
  logic [cfs_pkg::FreqW-1:0]    cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [39:0]                  s_tdata = '0;  // current_freq[26:0], step_count[34:27]
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [31:0]                  m_tdata;       // new_freq[26:0], wrap_flag[28:27]

  cfs_pkg::cfg_t band = ResetBand;
  tune_t         tunes_due[$];
  int            mismatches = 0;
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;
  bit            long_hold = 1'b0;

  tune_row_t directed [25] = '{
    '{ResetBand, 27'd14500000, 8'h00, 1'b1, '{27'd14500000, cfs_pkg::WRAP_NONE}},
    '{ResetBand, 27'd17400000, 8'h00, 1'b1, '{27'd17400000, cfs_pkg::WRAP_NONE}},
    '{ResetBand, 27'd17400000, 8'h01, 1'b1, '{27'd13600000, cfs_pkg::WRAP_LOWER}},
    '{ResetBand, 27'd13600000, 8'hFF, 1'b1, '{27'd17400000, cfs_pkg::WRAP_TOP}},
    '{ResetBand, 27'd0,        8'h80, 1'b1, '{27'd17400000, cfs_pkg::WRAP_TOP}},
    '{ResetBand, FreqMax,      8'h7F, 1'b1, '{27'd13600000, cfs_pkg::WRAP_LOWER}},
    '{ResetBand, FreqMax,      8'h80, 1'b1, '{27'd13600000, cfs_pkg::WRAP_LOWER}},
    '{ResetBand, 27'd14000000, 8'h7F, 1'b1, '{27'd14158750, cfs_pkg::WRAP_NONE}},
    '{ResetBand, 27'd14000000, 8'h80, 1'b1, '{27'd13840000, cfs_pkg::WRAP_NONE}},
    '{ResetBand, 27'd13600000, 8'h00, 1'b1, '{27'd13600000, cfs_pkg::WRAP_NONE}},
    '{AirBand,   27'd11800000, 8'h01, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{AirBand,   27'd11800833, 8'h01, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{AirBand,   27'd11801667, 8'h01, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{AirBand,   27'd11802499, 8'h00, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{AirBand,   27'd11800000, 8'hFF, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{AirBand,   27'd13697500, 8'h01, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{AirBand,   27'd11799999, 8'h00, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{ZeroStep,  27'd12000000, 8'h05, 1'b1, '{27'd12000000, cfs_pkg::WRAP_NONE}},
    '{ZeroStep,  27'd5000000,  8'h80, 1'b1, '{27'd20000000, cfs_pkg::WRAP_TOP}},
    '{Crossed,   27'd30000000, 8'h00, 1'b1, '{27'd20000000, cfs_pkg::WRAP_LOWER}},
    '{Crossed,   27'd5000000,  8'h00, 1'b1, '{27'd20000000, cfs_pkg::WRAP_TOP}},
    '{FullBand,  27'd0,        8'h7F, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{FullBand,  FreqMax,      8'h80, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{FullBand,  27'h2AAAAAA,  8'h55, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}},
    '{FullBand,  27'h5555555,  8'hAA, 1'b0, '{27'd0, cfs_pkg::WRAP_NONE}}
  };

  channel_frequency_stepper_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #15000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic tune_t next_channel(cfs_pkg::cfg_t c, logic [cfs_pkg::FreqW-1:0] f,
                                         logic [cfs_pkg::CountW-1:0] n);
    longint lo, hi, sum, off, blk, k, st, top;
    tune_t r;
    lo = longint'(c.lower);
    hi = longint'(c.upper);
    sum = longint'(f) + longint'($signed(n)) * longint'(c.step);
    if (c.step == cfs_pkg::StepW'(cfs_pkg::Grid833) && sum >= lo) begin
      off = sum - lo;
      blk = (off / longint'(cfs_pkg::GridBlock)) * longint'(cfs_pkg::GridBlock);
      k = (off - blk) / longint'(cfs_pkg::Grid833);
      if (k == 2) blk += 1;
      sum = lo + blk + k * longint'(cfs_pkg::Grid833);
    end
    if (sum > hi) begin
      r.freq = c.lower;
      r.wrap = cfs_pkg::WRAP_LOWER;
    end else if (sum < lo) begin
      st = (c.step == '0) ? 1 : longint'(c.step);
      top = (hi < lo) ? lo : lo + ((hi - lo) / st) * st;
      r.freq = cfs_pkg::FreqW'(top);
      r.wrap = cfs_pkg::WRAP_TOP;
    end else begin
      r.freq = cfs_pkg::FreqW'(sum);
      r.wrap = cfs_pkg::WRAP_NONE;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: checks each transfer against the oldest pending tune
  initial begin
    int stall;
    tune_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (tunes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: freq %0d wrap %0d", m_tdata[26:0], m_tdata[28:27]);
        end else begin
          want = tunes_due.pop_front();
          if (m_tdata[26:0] !== want.freq || m_tdata[28:27] !== want.wrap) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: freq exp %0d got %0d, wrap exp %0d got %0d",
                       want.freq, m_tdata[26:0], want.wrap, m_tdata[28:27]);
          end
        end
      end
      if (stall > 0) stall--;
      else stall = pick_gap();
      m_tready <= !long_hold && (stall == 0);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (hold_req);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic offer(logic [cfs_pkg::FreqW-1:0] f, logic [cfs_pkg::CountW-1:0] n,
                       bit typed, tune_t want);
    int gap;
    s_tdata <= {5'd0, n, f};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    tunes_due.push_back(typed ? want : next_channel(band, f, n));
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tunes_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_band(cfs_pkg::cfg_t c);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= cfs_pkg::REG_LOWER;
    cfg_data <= c.lower;
    @(posedge clk);
    cfg_index <= cfs_pkg::REG_UPPER;
    cfg_data <= c.upper;
    @(posedge clk);
    cfg_index <= cfs_pkg::REG_STEP;
    cfg_data <= cfs_pkg::FreqW'(c.step);
    @(posedge clk);
    cfg_we <= 1'b0;
    band = c;
  endtask

  function automatic cfs_pkg::cfg_t random_band(int phase);
    cfs_pkg::cfg_t c;
    int unsigned span;
    logic [cfs_pkg::StepW-1:0] steps [8] = '{16'd1, 16'd5, 16'd625, 16'd833, 16'd1000,
                                             16'd1250, 16'd2500, 16'hFFFF};
    case (phase)
      0: c = '{27'd0, FreqMax, 16'd1};
      1: c = '{FreqMax, FreqMax, 16'hFFFF};
      2: c = '{27'd0, 27'd0, 16'd833};
      3: c = '{27'($urandom_range(60000000, 90000000)), 27'($urandom_range(0, 50000000)),
               16'd1250};
      default: begin
        c.lower = cfs_pkg::FreqW'($urandom_range(0, 120000000));
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1000)
                                           : $urandom_range(10000, 20000000);
        c.upper = (longint'(c.lower) + span > longint'(FreqMax))
                  ? FreqMax : cfs_pkg::FreqW'(c.lower + span);
        case ($urandom_range(0, 3))
          0, 1: c.step = steps[$urandom_range(0, 7)];
          2: c.step = 16'd833;
          default: c.step = cfs_pkg::StepW'($urandom_range(1, 65535));
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [cfs_pkg::FreqW-1:0] pick_freq(cfs_pkg::cfg_t c);
    longint base, reach, v;
    if ($urandom_range(0, 4) == 0) return cfs_pkg::FreqW'($urandom());
    base = $urandom_range(0, 1) ? longint'(c.lower) : longint'(c.upper);
    reach = 130 * longint'(c.step) + 3000;
    v = base + longint'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > longint'(FreqMax)) v = longint'(FreqMax);
    return cfs_pkg::FreqW'(v);
  endfunction

  function automatic logic [cfs_pkg::CountW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2, 3: return cfs_pkg::CountW'($urandom_range(0, 6) - 3);
      default: return cfs_pkg::CountW'($urandom());
    endcase
  endfunction

  initial begin
    tune_t none;
    none = '{'0, cfs_pkg::WRAP_NONE};
    while (rst) @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].band != band) load_band(directed[i].band);
      offer(directed[i].freq, directed[i].count, directed[i].typed, directed[i].want);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      calm <= (p % 4 == 1);
      load_band(random_band(p));
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 4 && i == 20) hold_req = 1'b1;
        if (p == 6 && i == 95) drain();
        offer(pick_freq(band), pick_count(), 1'b0, none);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
